>>> design/amrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrc_pkg: shared types and constants for the alpha mask colorizer
// Payload structs, color layout, register indexes and the channel blend.
// ----------------------------------------------------------------------------
package amrc_pkg;

	localparam int unsigned ChanW   = 8;
	localparam int unsigned AlphaW  = 4;
	localparam int unsigned ColorW  = 3 * ChanW;
	localparam int unsigned PixelW  = 16;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [AlphaW-1:0] AlphaMax = 4'd15;

	// x / 15 for x < 3826 is ((x + 1) * 0x1111) >> 16
	localparam int unsigned SumW  = ChanW + AlphaW;
	localparam int unsigned RecipW = SumW + 13;

	localparam logic [ColorW-1:0] FgReset = 24'hFF_FFFF;
	localparam logic [ColorW-1:0] BgReset = 24'h00_0000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_FG_COLOR = 2'd0,
		REG_BG_COLOR = 2'd1,
		REG_BLANK    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [ChanW-1:0] red;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] blue;
	} color_t;

	typedef struct packed {
		logic [7:0] mask_byte;
		logic       row_present;
	} in_item_t;

	typedef struct packed {
		logic [PixelW-1:0] left_pixel;
		logic [PixelW-1:0] right_pixel;
	} out_item_t;

	// (f*a + b*(15-a)) / 15, truncating
	function automatic logic [ChanW-1:0] blend_channel(
		input logic [ChanW-1:0]  f,
		input logic [ChanW-1:0]  b,
		input logic [AlphaW-1:0] a
	);
		logic [SumW-1:0]   sum;
		logic [RecipW-1:0] y;
		logic [RecipW-1:0] prod;
		sum  = SumW'(f) * SumW'(a) + SumW'(b) * SumW'(AlphaMax - a);
		y    = RecipW'(sum) + RecipW'(1);
		prod = y + (y << 4) + (y << 8) + (y << 12);
		return prod[16 +: ChanW];
	endfunction

endpackage

>>> design/amrc_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amrc_shade: one pixel shader
// Blends foreground over background by a 4-bit alpha and packs to RGB565.
// ----------------------------------------------------------------------------
module amrc_shade (
	input  amrc_pkg::color_t            fg,
	input  amrc_pkg::color_t            bg,
	input  logic [amrc_pkg::AlphaW-1:0] alpha,
	output logic [amrc_pkg::PixelW-1:0] pixel
);
	import amrc_pkg::*;

	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;

	always_comb begin
		red   = blend_channel(fg.red,   bg.red,   alpha);
		green = blend_channel(fg.green, bg.green, alpha);
		blue  = blend_channel(fg.blue,  bg.blue,  alpha);
	end

	// keep the top 5:6:5 bits
	assign pixel = {red[7:3], green[7:2], blue[7:3]};

endmodule

>>> design/alpha_mask_rgb565_colorizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_mask_rgb565_colorizer_unit: text mask to RGB565 colorizer
// Turns one mask byte (two 4-bit alphas) into two blended RGB565 pixels.
// ----------------------------------------------------------------------------
// Path: an input transfer is captured in the input register, then blended
//   into the result register.
// Throughput: one item per cycle; the two-stage pipeline holds under stall.
// Reset: pipeline empty, fg_color = 0xFFFFFF, bg_color = 0, blank = 0.
module alpha_mask_rgb565_colorizer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  amrc_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output amrc_pkg::out_item_t           out_item,
	input  logic                          cfg_we,
	input  logic [amrc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [amrc_pkg::ColorW-1:0]   cfg_data
);
	import amrc_pkg::*;

	color_t    fg_q;
	color_t    bg_q;
	logic      blank_q;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;

	logic      adv_s1;
	logic      adv_s2;
	logic [AlphaW-1:0] left_alpha;
	logic [AlphaW-1:0] right_alpha;
	logic [PixelW-1:0] left_pix;
	logic [PixelW-1:0] right_pix;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q    <= FgReset;
			bg_q    <= BgReset;
			blank_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FG_COLOR: fg_q    <= cfg_data;
				REG_BG_COLOR: bg_q    <= cfg_data;
				REG_BLANK:    blank_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= in_item;
		end
		if (adv_s2 && valid_s1) begin
			item_s2 <= '{left_pixel: left_pix, right_pixel: right_pix};
		end
	end

	// blank or absent row: both alphas drop to zero
	always_comb begin
		if (blank_q || !item_s1.row_present) begin
			left_alpha  = '0;
			right_alpha = '0;
		end else begin
			left_alpha  = item_s1.mask_byte[7:4];
			right_alpha = item_s1.mask_byte[3:0];
		end
	end

	amrc_shade u_shade_left (
		.fg    (fg_q),
		.bg    (bg_q),
		.alpha (left_alpha),
		.pixel (left_pix)
	);

	amrc_shade u_shade_right (
		.fg    (fg_q),
		.bg    (bg_q),
		.alpha (right_alpha),
		.pixel (right_pix)
	);

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// an accepted transfer lands in the input register
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(in_valid && !in_stall) |-> valid_s1)
		else $error("accepted transfer not captured");

	// a full pipeline blocked at the output must stall the input
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("input taken while pipeline full and stalled");

	// blanking gives both pixels the background colour
	a_blank_same: assert property (@(posedge clk) disable iff (!arst_n)
		blank_q && out_valid |-> out_item.left_pixel == out_item.right_pixel)
		else $error("blank pixels differ");

endmodule

>>> verif/tb_alpha_mask_rgb565_colorizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_mask_rgb565_colorizer_unit: self-checking bench for the colorizer
// Drives a short table of directed mask bytes and register writes, then
// phases of random mask bytes under random foreground, background and blank
// settings. Every result is checked against the table or an in-bench blend model,
// with random idle bursts on both the input and the output side.
// ----------------------------------------------------------------------------
module tb_alpha_mask_rgb565_colorizer_unit;
	import amrc_pkg::*;

	localparam logic [CfgIdxW-1:0] RegSpare = 2'd3; // no register here, write is dropped
	localparam int unsigned PhaseCount = 8;
	localparam int unsigned PhaseItems = 110;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CfgIdxW-1:0] idx;
		logic [ColorW-1:0]  data;
		in_item_t           item;
		logic               has_exp;
		out_item_t          exp_px;
	} plan_row_t;

	// kind, register, data, {mask, present}, typed?, {left, right}
	localparam plan_row_t Plan[22] = '{
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hFF, 1'b1}, 1'b1, '{16'hFFFF, 16'hFFFF}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h00, 1'b1}, 1'b1, '{16'h0000, 16'h0000}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hF0, 1'b1}, 1'b1, '{16'hFFFF, 16'h0000}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h0F, 1'b1}, 1'b1, '{16'h0000, 16'hFFFF}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hFF, 1'b0}, 1'b1, '{16'h0000, 16'h0000}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h5A, 1'b1}, 1'b0, '{16'h0000, 16'h0000}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h87, 1'b1}, 1'b0, '{16'h0000, 16'h0000}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h1E, 1'b0}, 1'b1, '{16'h0000, 16'h0000}},
		'{ROW_CFG,  REG_BLANK,    24'h000001, '{8'h00, 1'b0}, 1'b0, '{16'h0, 16'h0}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hFF, 1'b1}, 1'b1, '{16'h0000, 16'h0000}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h3C, 1'b0}, 1'b1, '{16'h0000, 16'h0000}},
		'{ROW_CFG,  REG_BG_COLOR, 24'h123456, '{8'h00, 1'b0}, 1'b0, '{16'h0, 16'h0}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hFF, 1'b1}, 1'b1, '{16'h11AA, 16'h11AA}},
		'{ROW_CFG,  RegSpare,     24'hFFFFFF, '{8'h00, 1'b0}, 1'b0, '{16'h0, 16'h0}},
		// upper bits of a blank write are dropped, so this clears blank
		'{ROW_CFG,  REG_BLANK,    24'hFFFFFE, '{8'h00, 1'b0}, 1'b0, '{16'h0, 16'h0}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hFF, 1'b1}, 1'b1, '{16'hFFFF, 16'hFFFF}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h00, 1'b1}, 1'b1, '{16'h11AA, 16'h11AA}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'h69, 1'b1}, 1'b0, '{16'h0000, 16'h0000}},
		'{ROW_CFG,  REG_FG_COLOR, 24'h000000, '{8'h00, 1'b0}, 1'b0, '{16'h0, 16'h0}},
		'{ROW_CFG,  REG_BG_COLOR, 24'hFFFFFF, '{8'h00, 1'b0}, 1'b0, '{16'h0, 16'h0}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hF0, 1'b1}, 1'b1, '{16'h0000, 16'hFFFF}},
		'{ROW_ITEM, REG_FG_COLOR, 24'h0, '{8'hA5, 1'b1}, 1'b0, '{16'h0000, 16'h0000}}
	};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_item;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_item;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [ColorW-1:0]  cfg_data;

	// shadow copy of the block's registers
	logic [ColorW-1:0] fg_shadow = FgReset;
	logic [ColorW-1:0] bg_shadow = BgReset;
	logic              blank_shadow = 1'b0;

	out_item_t   pending_pixels[$];
	int unsigned errors = 0;
	int unsigned n_sent = 0;
	int unsigned n_checked = 0;
	int unsigned n_cfg = 0;
	logic        calm = 1'b0;

	alpha_mask_rgb565_colorizer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [ChanW-1:0] mix_channel(logic [ChanW-1:0] f, logic [ChanW-1:0] b,
			logic [AlphaW-1:0] a);
		int unsigned acc;
		acc = int'(f) * int'(a) + int'(b) * (15 - int'(a));
		return ChanW'(acc / 15);
	endfunction

	function automatic logic [PixelW-1:0] shade565(logic [AlphaW-1:0] a);
		color_t fg;
		color_t bg;
		logic [ChanW-1:0] r;
		logic [ChanW-1:0] g;
		logic [ChanW-1:0] b;
		fg = color_t'(fg_shadow);
		bg = color_t'(bg_shadow);
		r  = mix_channel(fg.red, bg.red, a);
		g  = mix_channel(fg.green, bg.green, a);
		b  = mix_channel(fg.blue, bg.blue, a);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	function automatic out_item_t colorize(in_item_t it);
		logic [7:0] m;
		out_item_t  px;
		m = (blank_shadow || !it.row_present) ? 8'h00 : it.mask_byte;
		px.left_pixel  = shade565(m[7:4]);
		px.right_pixel = shade565(m[3:0]);
		return px;
	endfunction

	function automatic logic [ColorW-1:0] pick_color();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return ColorW'($urandom);
		endcase
	endfunction

	task automatic note_failure(string msg);
		errors++;
		if (errors <= 10) begin
			$display("%t: %s", $realtime, msg);
		end
	endtask

	// output side: random stall bursts, none during the calm tail
	initial begin : stall_gen
		int unsigned burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				burst = 0;
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 4) == 0) begin
				burst = $urandom_range(0, 10);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : pixel_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				note_failure($sformatf("result with nothing pending: left %h right %h",
					out_item.left_pixel, out_item.right_pixel));
			end else begin
				want = pending_pixels.pop_front();
				n_checked++;
				if (out_item.left_pixel !== want.left_pixel) begin
					note_failure($sformatf("left_pixel: expected %h, got %h",
						want.left_pixel, out_item.left_pixel));
				end
				if (out_item.right_pixel !== want.right_pixel) begin
					note_failure($sformatf("right_pixel: expected %h, got %h",
						want.right_pixel, out_item.right_pixel));
				end
			end
		end
	end

	task automatic send_mask(in_item_t it, logic has_exp, out_item_t exp_px);
		int unsigned gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		pending_pixels.push_back(has_exp ? exp_px : colorize(it));
		n_sent++;
	endtask

	// drop valid and wait until the pipeline has drained
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_FG_COLOR: fg_shadow = data;
			REG_BG_COLOR: bg_shadow = data;
			REG_BLANK:    blank_shadow = data[0];
			default: ;
		endcase
		n_cfg++;
	endtask

	initial begin : stimulus
		in_item_t it;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(Plan); i++) begin
			if (Plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(Plan[i].idx, Plan[i].data);
				@(negedge clk);
				cfg_we <= 1'b0;
			end else begin
				send_mask(Plan[i].item, Plan[i].has_exp, Plan[i].exp_px);
			end
		end

		for (int ph = 0; ph < PhaseCount; ph++) begin
			settle();
			calm = (ph == PhaseCount - 1);
			write_reg(REG_FG_COLOR, pick_color());
			write_reg(REG_BG_COLOR, pick_color());
			write_reg(REG_BLANK, {23'($urandom), 1'($urandom_range(0, 3) == 0)});
			if ($urandom_range(0, 2) == 0) begin
				write_reg(RegSpare, ColorW'($urandom));
			end
			@(negedge clk);
			cfg_we <= 1'b0;
			for (int k = 0; k < PhaseItems; k++) begin
				it.mask_byte   = 8'($urandom);
				it.row_present = ($urandom_range(0, 9) != 0);
				send_mask(it, 1'b0, '0);
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (pending_pixels.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", pending_pixels.size()));
		end
		$display("Covered %0d mask transfers, %0d results checked, %0d register writes",
			n_sent, n_checked, n_cfg);
		$display("over %0d colour phases with idle bursts on both sides; %0d mismatches",
			PhaseCount, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
